// ----- rtl/bpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, codes and helpers of the Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int MAX_ORDER = 4;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic REG_U_ORDER = 1'b0;
    localparam logic REG_V_ORDER = 1'b1;

    // Weight unit sequence: steps 0 to 6 use the multiplier, the last forms weights.
    localparam logic [2:0] WSTEP_SS   = 3'd0;
    localparam logic [2:0] WSTEP_ST   = 3'd1;
    localparam logic [2:0] WSTEP_TT   = 3'd2;
    localparam logic [2:0] WSTEP_SSS  = 3'd3;
    localparam logic [2:0] WSTEP_SST  = 3'd4;
    localparam logic [2:0] WSTEP_STT  = 3'd5;
    localparam logic [2:0] WSTEP_TTT  = 3'd6;
    localparam logic [2:0] WSTEP_FORM = 3'd7;

    typedef struct packed {
        logic              cmd;
        logic [1:0]        point_row;
        logic [1:0]        point_col;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [16:0]       u_param;
        logic [16:0]       v_param;
    } item_t;

    typedef struct packed {
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } point_t;

    typedef logic [16:0] weight_t;
    typedef weight_t [MAX_ORDER-1:0] wvec_t;

    // Control of a weight unit.
    typedef struct packed {
        logic       load;
        logic       run;
        logic [2:0] step;
    } wctl_t;

    // Control of the accumulation datapath.
    typedef struct packed {
        logic clear;
        logic issue;
        logic finish;
    } actl_t;

    function automatic logic [2:0] clamp_order(input logic [2:0] ord);
        logic [2:0] res;
        begin
            res = ord;
            if (ord < 3'd2)
                res = 3'd2;
            else if (ord > 3'(MAX_ORDER))
                res = 3'(MAX_ORDER);
            return res;
        end
    endfunction

endpackage

// ----- rtl/bezier_patch_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_patch_evaluator
// Tensor-product Bezier patch of order 2 to 4 in u and v over a 4x4 grid
// of control points held in a synchronous memory.
// ----------------------------------------------------------------------------
//   port group                      role
//   start, busy, item               command word in, taken when start & !busy
//   done, result                    result word out, valid for one cycle
//   cfg_we, cfg_index, cfg_data     register write, index 0 u_order, 1 v_order
//
// A load word writes the memory at once; busy stays low.
// An evaluate word runs from accept to done through the two weight units,
// one memory read per control point, and the drain of the multiply
// pipeline and rounding.
// Reset clears only control state; the memory is not cleared.
// The receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module bezier_patch_evaluator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bpe_pkg::item_t   item,
    output logic             done,
    output bpe_pkg::result_t result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [2:0]       cfg_data
);
    import bpe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WGT   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [2:0] nu_reg, nu_next;
    logic [2:0] nv_reg, nv_next;
    logic [2:0] u_order_reg;
    logic [2:0] v_order_reg;

    logic   accept;
    logic   last_col;
    logic   last_row;
    wctl_t  wctl;
    actl_t  actl;
    wvec_t  wu;
    wvec_t  wv;
    point_t wr_point;
    point_t rd_point;

    assign accept   = start & ~busy;
    assign busy     = (state_reg != ST_IDLE);
    assign last_col = ({1'b0, col_reg} == nu_reg - 3'd1);
    assign last_row = ({1'b0, row_reg} == nv_reg - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_order_reg <= 3'd4;
            v_order_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_U_ORDER: u_order_reg <= cfg_data;
                REG_V_ORDER: v_order_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        nu_next    = nu_reg;
        nv_next    = nv_reg;
        wctl.load  = 1'b0;
        wctl.run   = 1'b0;
        wctl.step  = cnt_reg;
        actl.clear = 1'b0;
        actl.issue = 1'b0;
        actl.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.cmd == CMD_EVAL)
                begin
                    nu_next    = clamp_order(u_order_reg);
                    nv_next    = clamp_order(v_order_reg);
                    wctl.load  = 1'b1;
                    actl.clear = 1'b1;
                    cnt_next   = WSTEP_SS;
                    state_next = ST_WGT;
                end
            end
            ST_WGT:
            begin
                wctl.run = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == WSTEP_FORM)
                begin
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                actl.issue = 1'b1;
                if (last_col)
                begin
                    col_next = 2'd0;
                    row_next = row_reg + 2'd1;
                    if (last_row)
                    begin
                        cnt_next   = 3'd0;
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd1)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                actl.finish = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            nu_reg    <= 3'd4;
            nv_reg    <= 3'd4;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            nu_reg    <= nu_next;
            nv_reg    <= nv_next;
        end
    end

    assign wr_point.x = item.point_x;
    assign wr_point.y = item.point_y;

    // Loads only happen while idle, so a read never overlaps a write.
    bpe_store u_store (
        .clk   (clk),
        .we    (accept && item.cmd == CMD_LOAD),
        .waddr ({item.point_row, item.point_col}),
        .wdata (wr_point),
        .re    (actl.issue),
        .raddr ({row_reg, col_reg}),
        .rdata (rd_point)
    );

    bpe_weight u_weight_u (
        .clk     (clk),
        .ctl     (wctl),
        .t_in    (item.u_param),
        .ord_in  (nu_next),
        .weights (wu)
    );

    bpe_weight u_weight_v (
        .clk     (clk),
        .ctl     (wctl),
        .t_in    (item.v_param),
        .ord_in  (nv_next),
        .weights (wv)
    );

    bpe_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (actl),
        .wu_sel (wu[col_reg]),
        .wv_sel (wv[row_reg]),
        .pt     (rd_point),
        .done   (done),
        .result (result)
    );

endmodule

// ----- rtl/bpe_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_weight
// Bernstein weights of one parameter, formed step by step through one
// shared multiplier and rounded to Q1.16.
// ----------------------------------------------------------------------------
module bpe_weight (
    input  logic           clk,
    input  bpe_pkg::wctl_t ctl,
    input  logic [16:0]    t_in,
    input  logic [2:0]     ord_in,
    output bpe_pkg::wvec_t weights
);
    import bpe_pkg::*;

    logic [16:0] t_reg;
    logic [16:0] s_reg;
    logic [2:0]  ord_reg;
    logic [32:0] ss_reg;
    logic [32:0] st_reg;
    logic [32:0] tt_reg;
    logic [48:0] sss_reg;
    logic [48:0] sst_reg;
    logic [48:0] stt_reg;
    logic [48:0] ttt_reg;
    wvec_t       w_reg;
    wvec_t       w_next;

    logic [32:0] op_a;
    logic [16:0] op_b;
    logic [49:0] prod;
    logic [16:0] t_sat;

    logic [33:0] r3_0;
    logic [34:0] r3_1;
    logic [33:0] r3_2;
    logic [50:0] r4_0;
    logic [50:0] r4_1;
    logic [50:0] r4_2;
    logic [50:0] r4_3;

    assign t_sat = (t_in > ONE_Q16) ? ONE_Q16 : t_in;

    always_comb
    begin
        case (ctl.step)
            WSTEP_SS:  begin op_a = {16'd0, s_reg}; op_b = s_reg; end
            WSTEP_ST:  begin op_a = {16'd0, s_reg}; op_b = t_reg; end
            WSTEP_TT:  begin op_a = {16'd0, t_reg}; op_b = t_reg; end
            WSTEP_SSS: begin op_a = ss_reg;         op_b = s_reg; end
            WSTEP_SST: begin op_a = ss_reg;         op_b = t_reg; end
            WSTEP_STT: begin op_a = tt_reg;         op_b = s_reg; end
            WSTEP_TTT: begin op_a = tt_reg;         op_b = t_reg; end
            default:   begin op_a = 33'd0;          op_b = 17'd0; end
        endcase
        prod = {17'd0, op_a} * {33'd0, op_b};
    end

    // Rounding adds half an LSB of the target format before the bits drop.
    always_comb
    begin
        r3_0 = {1'b0, ss_reg} + 34'd32768;
        r3_1 = {1'b0, st_reg, 1'b0} + 35'd32768;
        r3_2 = {1'b0, tt_reg} + 34'd32768;
        r4_0 = {2'b00, sss_reg} + 51'h80000000;
        r4_1 = {2'b00, sst_reg} + {1'b0, sst_reg, 1'b0} + 51'h80000000;
        r4_2 = {2'b00, stt_reg} + {1'b0, stt_reg, 1'b0} + 51'h80000000;
        r4_3 = {2'b00, ttt_reg} + 51'h80000000;
        w_next = '0;
        case (ord_reg)
            3'd2:
            begin
                w_next[0] = s_reg;
                w_next[1] = t_reg;
            end
            3'd3:
            begin
                w_next[0] = r3_0[32:16];
                w_next[1] = r3_1[32:16];
                w_next[2] = r3_2[32:16];
            end
            default:
            begin
                w_next[0] = r4_0[48:32];
                w_next[1] = r4_1[48:32];
                w_next[2] = r4_2[48:32];
                w_next[3] = r4_3[48:32];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            t_reg   <= t_sat;
            s_reg   <= ONE_Q16 - t_sat;
            ord_reg <= ord_in;
        end
        if (ctl.run)
        begin
            case (ctl.step)
                WSTEP_SS:   ss_reg  <= prod[32:0];
                WSTEP_ST:   st_reg  <= prod[32:0];
                WSTEP_TT:   tt_reg  <= prod[32:0];
                WSTEP_SSS:  sss_reg <= prod[48:0];
                WSTEP_SST:  sst_reg <= prod[48:0];
                WSTEP_STT:  stt_reg <= prod[48:0];
                WSTEP_TTT:  ttt_reg <= prod[48:0];
                default:    w_reg   <= w_next;
            endcase
        end
    end

    assign weights = w_reg;

endmodule

// ----- rtl/bpe_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_store
// Control point memory: 16 words of (x, y), one write and one registered
// read port.
// ----------------------------------------------------------------------------
module bpe_store (
    input  logic            clk,
    input  logic            we,
    input  logic [3:0]      waddr,
    input  bpe_pkg::point_t wdata,
    input  logic            re,
    input  logic [3:0]      raddr,
    output bpe_pkg::point_t rdata
);
    import bpe_pkg::*;

    point_t mem [16];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bpe_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_accum
// Weight product, coordinate multiply and accumulation, one control point
// per cycle, followed by rounding to Q16.8 and saturation.
// ----------------------------------------------------------------------------
module bpe_accum (
    input  logic             clk,
    input  logic             rst_n,
    input  bpe_pkg::actl_t   ctl,
    input  bpe_pkg::weight_t wu_sel,
    input  bpe_pkg::weight_t wv_sel,
    input  bpe_pkg::point_t  pt,
    output logic             done,
    output bpe_pkg::result_t result
);
    import bpe_pkg::*;

    logic [33:0]        wp_reg;
    logic               v1_reg;
    logic signed [41:0] px_reg;
    logic signed [41:0] py_reg;
    logic               v2_reg;
    logic signed [45:0] acc_x_reg;
    logic signed [45:0] acc_y_reg;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;

    logic [34:0]        wq_sum;
    logic signed [17:0] wq;
    logic signed [45:0] rx;
    logic signed [45:0] ry;
    logic               clip_x;
    logic               clip_y;

    assign wq_sum = {1'b0, wp_reg} + 35'd32768;
    assign wq     = $signed({1'b0, wq_sum[32:16]});

    // The memory word arrives in the cycle after its address, next to wp_reg.
    always_ff @(posedge clk)
    begin
        wp_reg <= {17'd0, wu_sel} * {17'd0, wv_sel};
        px_reg <= wq * pt.x;
        py_reg <= wq * pt.y;
        if (ctl.clear)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_x_reg <= acc_x_reg + {{4{px_reg[41]}}, px_reg};
            acc_y_reg <= acc_y_reg + {{4{py_reg[41]}}, py_reg};
        end
        if (ctl.finish)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctl.issue;
            v2_reg   <= v1_reg;
            done_reg <= ctl.finish;
        end
    end

    // An arithmetic shift of the biased sum rounds to nearest in Q16.8, ties up.
    always_comb
    begin
        rx = (acc_x_reg + 46'sd32768) >>> 16;
        ry = (acc_y_reg + 46'sd32768) >>> 16;
        clip_x = (rx[29:23] != {7{rx[29]}});
        clip_y = (ry[29:23] != {7{ry[29]}});
        result_next.out_x = clip_x ? (rx[29] ? 24'sh800000 : 24'sh7FFFFF) : rx[23:0];
        result_next.out_y = clip_y ? (ry[29] ? 24'sh800000 : 24'sh7FFFFF) : ry[23:0];
        result_next.saturated = clip_x | clip_y;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/sv/bezier_patch_evaluator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_patch_evaluator_test
// Self-checking bench for the Bezier patch evaluator. Load and evaluate
// words are queued per phase, and a clocked driver feeds them to the block
// with random idle bursts. A bit-exact fixed-point model of the patch
// predicts every evaluation, and a monitor compares each result strobe with
// the oldest prediction. Phases step through eleven order settings,
// including values that the block must clamp.
// ----------------------------------------------------------------------------
module bezier_patch_evaluator_test;

    import bpe_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 120;
    localparam int NUM_SETTINGS  = 11;
    localparam int REPORT_LIMIT  = 10;
    localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] COORD_MIN = -24'sh800000;

    typedef logic [3:0][16:0] bern_vec_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    item_t      item      = '0;
    logic       done;
    result_t    result;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = REG_U_ORDER;
    logic [2:0] cfg_data  = 3'd0;

    // Model state: control point grid and order registers.
    logic signed [23:0] pts_x [16];
    logic signed [23:0] pts_y [16];
    logic [2:0]         u_ord = 3'd4;
    logic [2:0]         v_ord = 3'd4;

    item_t   pending_words [$];
    result_t expected_points [$];

    int queued_count   = 0;
    int accepted_count = 0;
    int idle_pct       = 0;
    int idle_left      = 0;
    int fail_count     = 0;
    int loads_done     = 0;
    int evals_done     = 0;
    int results_seen   = 0;
    int clipped_seen   = 0;
    int cycle_count    = 0;

    bezier_patch_evaluator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int active_order(input logic [2:0] ord);
        if (ord < 3'd2)
            return 2;
        if (ord > 3'd4)
            return 4;
        return int'(ord);
    endfunction

    // Bernstein weights of the given order, each rounded to Q1.16.
    function automatic bern_vec_t bern_weights(input int ord, input logic [16:0] t_in);
        longint unsigned t;
        longint unsigned s;
        longint unsigned half;
        bern_vec_t       w;
        t = (t_in > ONE_Q16) ? 64'(ONE_Q16) : 64'(t_in);
        s = 64'd65536 - t;
        half = 64'd1 << 31;
        w = '0;
        case (ord)
            2:
            begin
                w[0] = 17'(s);
                w[1] = 17'(t);
            end
            3:
            begin
                w[0] = 17'((s * s + 64'd32768) >> 16);
                w[1] = 17'((64'd2 * s * t + 64'd32768) >> 16);
                w[2] = 17'((t * t + 64'd32768) >> 16);
            end
            default:
            begin
                w[0] = 17'((s * s * s + half) >> 32);
                w[1] = 17'((64'd3 * s * s * t + half) >> 32);
                w[2] = 17'((64'd3 * s * t * t + half) >> 32);
                w[3] = 17'((t * t * t + half) >> 32);
            end
        endcase
        return w;
    endfunction

    function automatic result_t surface_point(input logic [16:0] u, input logic [16:0] v);
        bern_vec_t wu;
        bern_vec_t wv;
        longint    acc_x;
        longint    acc_y;
        longint    w;
        longint    rx;
        longint    ry;
        int        nu;
        int        nv;
        int        r;
        int        c;
        result_t   res;
        nu = active_order(u_ord);
        nv = active_order(v_ord);
        wu = bern_weights(nu, u);
        wv = bern_weights(nv, v);
        acc_x = 0;
        acc_y = 0;
        for (r = 0; r < nv; r++)
        begin
            for (c = 0; c < nu; c++)
            begin
                w = longint'((64'(wu[c]) * 64'(wv[r]) + 64'd32768) >> 16);
                acc_x += w * longint'(pts_x[r * 4 + c]);
                acc_y += w * longint'(pts_y[r * 4 + c]);
            end
        end
        // An arithmetic shift of the signed sum is the floor division.
        rx = (acc_x + 32768) >>> 16;
        ry = (acc_y + 32768) >>> 16;
        res.saturated = 1'b0;
        if (rx > 8388607)
        begin
            rx = 8388607;
            res.saturated = 1'b1;
        end
        else if (rx < -8388608)
        begin
            rx = -8388608;
            res.saturated = 1'b1;
        end
        if (ry > 8388607)
        begin
            ry = 8388607;
            res.saturated = 1'b1;
        end
        else if (ry < -8388608)
        begin
            ry = -8388608;
            res.saturated = 1'b1;
        end
        res.out_x = rx[23:0];
        res.out_y = ry[23:0];
        return res;
    endfunction

    function automatic void take_word(input item_t w);
        if (w.cmd == CMD_LOAD)
        begin
            pts_x[{w.point_row, w.point_col}] = w.point_x;
            pts_y[{w.point_row, w.point_col}] = w.point_y;
            loads_done++;
        end
        else
        begin
            expected_points.insert(expected_points.size(),
                                   surface_point(w.u_param, w.v_param));
            evals_done++;
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic logic [16:0] pick_param();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 17'd0;
        if (sel == 1)
            return ONE_Q16;
        if (sel <= 7)
            return 17'($urandom_range(0, 65536));
        return 17'($urandom);
    endfunction

    function automatic logic signed [23:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return COORD_MAX;
        if (sel == 1)
            return COORD_MIN;
        return 24'($urandom);
    endfunction

    // Fields that a word does not use carry random values.
    function automatic item_t load_word(input logic [1:0] row, input logic [1:0] col,
                                        input logic signed [23:0] x,
                                        input logic signed [23:0] y);
        item_t w;
        w.cmd       = CMD_LOAD;
        w.point_row = row;
        w.point_col = col;
        w.point_x   = x;
        w.point_y   = y;
        w.u_param   = 17'($urandom);
        w.v_param   = 17'($urandom);
        return w;
    endfunction

    function automatic item_t eval_word(input logic [16:0] u, input logic [16:0] v);
        item_t w;
        w.cmd       = CMD_EVAL;
        w.point_row = 2'($urandom);
        w.point_col = 2'($urandom);
        w.point_x   = 24'($urandom);
        w.point_y   = 24'($urandom);
        w.u_param   = u;
        w.v_param   = v;
        return w;
    endfunction

    task automatic push_word(input item_t w);
        pending_words.insert(pending_words.size(), w);
        queued_count++;
    endtask

    task automatic load_flat_grid(input logic signed [23:0] x, input logic signed [23:0] y);
        int k;
        for (k = 0; k < 16; k++)
            push_word(load_word(2'(k >> 2), 2'(k), x, y));
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_orders(input logic [2:0] u, input logic [2:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_U_ORDER;
        cfg_data  <= u;
        u_ord = u;
        @(posedge clk);
        cfg_index <= REG_V_ORDER;
        cfg_data  <= v;
        v_ord = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: holds a word on the port until the block takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                take_word(item);
                accepted_count++;
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() != 0 && idle_pct > 0 &&
                     $urandom_range(0, 99) < idle_pct)
            begin
                idle_left = $urandom_range(0, 7);
                start <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                item  <= pending_words.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                note_failure($sformatf("result with no prediction: x=%0d y=%0d sat=%0b",
                                       result.out_x, result.out_y, result.saturated));
            end
            else
            begin
                want = expected_points.pop_front();
                results_seen++;
                if (want.saturated)
                    clipped_seen++;
                if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
                    result.saturated !== want.saturated)
                    note_failure($sformatf(
                        "result %0d: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                        results_seen, want.out_x, want.out_y, want.saturated,
                        result.out_x, result.out_y, result.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_points.size());
            $display("bezier_patch_evaluator_test failed");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] u_set [NUM_SETTINGS];
        logic [2:0] v_set [NUM_SETTINGS];
        int         idle_set [NUM_SETTINGS];
        int         p;
        int         n;
        u_set    = '{3'd2, 3'd3, 3'd2, 3'd4, 3'd3, 3'd4, 3'd0, 3'd7, 3'd6, 3'd1, 3'd4};
        v_set    = '{3'd2, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd1, 3'd5, 3'd2, 3'd7, 3'd4};
        idle_set = '{30, 0, 20, 50, 10, 30, 0, 25, 40, 0, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset orders: every grid entry written first,
        // then corners, the midpoint, parameters above one and a point at one and two thirds.
        idle_pct = 0;
        load_flat_grid(COORD_MAX, COORD_MIN);
        push_word(eval_word(17'd0, 17'd0));
        push_word(eval_word(ONE_Q16, ONE_Q16));
        push_word(eval_word(17'd0, ONE_Q16));
        push_word(eval_word(ONE_Q16, 17'd0));
        push_word(eval_word(17'd32768, 17'd32768));
        push_word(eval_word(17'h1FFFF, 17'h10001));
        push_word(eval_word(17'd21845, 17'd43690));
        wait_idle();

        for (p = 0; p < NUM_SETTINGS; p++)
        begin
            write_orders(u_set[p], v_set[p]);
            idle_pct = idle_set[p];
            // Two phases start from a uniform extreme grid to drive the clip.
            if (p == 3)
                load_flat_grid(COORD_MAX, COORD_MIN);
            else if (p == 8)
                load_flat_grid(COORD_MIN, COORD_MAX);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                    push_word(eval_word(pick_param(), pick_param()));
                else
                    push_word(load_word(2'($urandom), 2'($urandom),
                                        pick_coord(), pick_coord()));
            end
            // The sender holds off here until every prediction has been met.
            wait_idle();
        end

        if (expected_points.size() != 0)
            note_failure($sformatf("%0d predictions never met", expected_points.size()));
        $display("Covered %0d point loads and %0d evaluations over %0d order settings;",
                 loads_done, evals_done, NUM_SETTINGS + 1);
        $display("%0d results checked, %0d of them clipped, %0d failures.",
                 results_seen, clipped_seen, fail_count);
        if (fail_count == 0)
            $display("bezier_patch_evaluator_test passed");
        else
            $display("bezier_patch_evaluator_test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bpe_pkg.sv
rtl/bpe_weight.sv
rtl/bpe_store.sv
rtl/bpe_accum.sv
rtl/bezier_patch_evaluator.sv
tb/sv/bezier_patch_evaluator_test.sv
